>>> hw/rtl/ctdd_pkg.sv
// shared types, codes and constants of the compact tensor descriptor decoder
package ctdd_pkg;

    localparam int S_DATA_W = 512;
    localparam int M_DATA_W = 168;
    localparam int RES_W    = 163;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FORMAT   = 3'd1,
        ST_CONTROL  = 3'd2,
        ST_RESERVED = 3'd3,
        ST_STRIDE   = 3'd4,
        ST_EXTENT   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        KIND_U32 = 2'd0,
        KIND_F32 = 2'd1,
        KIND_F16 = 2'd2
    } elem_kind_t;

    localparam logic [15:0] FMT_SWZ_MASK = 16'h6000;
    localparam logic [15:0] FMT_1D_U32   = 16'h0100;
    localparam logic [15:0] FMT_1D_F32   = 16'h0380;
    localparam logic [15:0] FMT_2D_F16   = 16'h0310;
    localparam logic [15:0] FMT_2D_F32   = 16'h0390;
    localparam logic [15:0] FMT_3D       = 16'h03a0;
    localparam logic [15:0] FMT_4D       = 16'h03b0;
    localparam logic [15:0] FMT_5D       = 16'h03c0;
    localparam logic [15:0] CTL_2D_ALT   = 16'h0020;

    // one classified descriptor as it waits in the queue
    typedef struct packed {
        status_t          status;
        logic [2:0]       rank;
        elem_kind_t       kind;
        logic [2:0]       esize;
        logic [1:0]       swz;
        logic [63:0]      base;
        logic [4:0][31:0] ext;
        logic [4:0][7:0]  box;
        logic [3:0][31:0] strd;   // strides of dimensions 1..4
    } desc_t;

    typedef struct packed {
        logic  valid;
        desc_t desc;
    } q_head_t;

    // result payload, status in the lowest bits
    typedef struct packed {
        logic [35:0] stride_size;
        logic [8:0]  box_size;
        logic [31:0] extent;
        logic [2:0]  dim_index;
        logic [63:0] base_address;
        logic [7:0]  swizzle_size;
        logic [2:0]  element_size;
        elem_kind_t  element_kind;
        logic [2:0]  rank;
        status_t     status;
    } res_t;

endpackage

>>> hw/rtl/ctdd_front.sv
// front end: accepts a descriptor and classifies it into rank, status and fields
module ctdd_front (
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ctdd_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  logic                          q_full,
    output logic                          q_push,
    output ctdd_pkg::desc_t               q_desc
);
    import ctdd_pkg::*;

    logic [7:0][63:0] w;
    logic [15:0]      fmt;
    logic [15:0]      ctl;
    logic [2:0]       rank;
    logic             ctl_bad;
    logic             rsv_bad;
    logic             strd_bad;
    logic             ext_bad;
    logic [4:0][31:0] ext;
    logic [4:0][7:0]  box;
    logic [3:0][31:0] strd;

    assign w    = s_axis_tdata;
    assign fmt  = w[1][15:0] & ~FMT_SWZ_MASK;
    assign ctl  = w[1][31:16];
    assign ext  = {w[6][31:0], w[5][63:32], w[5][31:0], w[4][63:32], w[4][31:0]};
    assign box  = {w[7][31:24], w[7][23:16], w[7][15:8], w[7][7:0], w[6][63:56]};
    assign strd = {w[3][31:0], w[2][63:32], w[2][31:0], w[1][63:32]};

    always_comb begin
        unique case (fmt)
            FMT_1D_U32, FMT_1D_F32: rank = 3'd1;
            FMT_2D_F16, FMT_2D_F32: rank = 3'd2;
            FMT_3D:                 rank = 3'd3;
            FMT_4D:                 rank = 3'd4;
            FMT_5D:                 rank = 3'd5;
            default:                rank = 3'd0;
        endcase
    end

    always_comb begin
        ctl_bad = 1'b0;
        rsv_bad = 1'b0;
        unique case (rank)
            3'd1: begin
                // rank 1 also rejects any stride bits as a control failure
                ctl_bad = (w[1][63:16] != '0);
                rsv_bad = (w[2] != '0) || (w[3] != '0) || (w[5] != '0) ||
                          (w[4][63:32] != '0) || (w[6][55:0] != '0) || (w[7] != '0);
            end
            3'd2: begin
                ctl_bad = (ctl != '0) && (ctl != CTL_2D_ALT);
                rsv_bad = (w[2] != '0) || (w[3] != '0) || (w[5] != '0) ||
                          (w[6][55:0] != '0) || (w[7][63:8] != '0);
            end
            3'd3: begin
                ctl_bad = (ctl != '0);
                rsv_bad = (w[2][63:32] != '0) || (w[3] != '0) || (w[5][63:32] != '0) ||
                          (w[6][55:0] != '0) || (w[7][63:16] != '0);
            end
            3'd4: begin
                ctl_bad = (ctl != '0);
                rsv_bad = (w[3] != '0) || (w[6][55:0] != '0) || (w[7][63:24] != '0);
            end
            3'd5: begin
                ctl_bad = (ctl != '0);
                rsv_bad = (w[3][63:32] != '0) || (w[6][55:32] != '0) ||
                          (w[7][63:32] != '0);
            end
            default: begin
                ctl_bad = 1'b0;
                rsv_bad = 1'b0;
            end
        endcase
    end

    always_comb begin
        strd_bad = 1'b0;
        ext_bad  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if ((3'(i + 1) < rank) && (strd[i] == '0)) begin
                strd_bad = 1'b1;
            end
        end
        for (int i = 0; i < 5; i++) begin
            if ((3'(i) < rank) && (ext[i] == '1)) begin
                ext_bad = 1'b1;
            end
        end
    end

    always_comb begin
        q_desc      = '0;
        q_desc.rank = rank;
        q_desc.swz  = w[1][14:13];
        q_desc.base = w[0];
        q_desc.ext  = ext;
        q_desc.box  = box;
        q_desc.strd = strd;
        if (fmt == FMT_1D_U32) begin
            q_desc.kind  = KIND_U32;
            q_desc.esize = 3'd4;
        end else if (fmt == FMT_2D_F16) begin
            q_desc.kind  = KIND_F16;
            q_desc.esize = 3'd2;
        end else begin
            q_desc.kind  = KIND_F32;
            q_desc.esize = 3'd4;
        end
        // first failing check wins
        if (rank == 3'd0) begin
            q_desc.status = ST_FORMAT;
        end else if (ctl_bad) begin
            q_desc.status = ST_CONTROL;
        end else if (rsv_bad) begin
            q_desc.status = ST_RESERVED;
        end else if (strd_bad) begin
            q_desc.status = ST_STRIDE;
        end else if (ext_bad) begin
            q_desc.status = ST_EXTENT;
        end else begin
            q_desc.status = ST_OK;
        end
    end

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

endmodule

>>> hw/rtl/ctdd_queue.sv
// two-entry queue of classified descriptors between front and back end
module ctdd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ctdd_pkg::desc_t   push_desc,
    output logic              full,
    output ctdd_pkg::q_head_t head,
    input  logic              pop
);
    import ctdd_pkg::*;

    desc_t      entries_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != '0);
    assign head.desc  = entries_reg[rd_ptr_reg];

endmodule

>>> hw/rtl/ctdd_back.sv
// back end: walks the queued descriptor and emits header and dimension results
module ctdd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ctdd_pkg::q_head_t             q_head,
    output logic                          q_pop,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ctdd_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast
);
    import ctdd_pkg::*;

    desc_t       d;
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;
    logic        valid_reg;
    logic        valid_next;
    res_t        res_reg;
    res_t        res_next;
    logic        user_reg;
    logic        last_reg;
    logic        hdr;
    logic        ok;
    logic        res_last;
    logic        load;
    logic [31:0] dim_ext;
    logic [7:0]  dim_box;
    logic [35:0] dim_strd;

    assign d        = q_head.desc;
    assign hdr      = (cnt_reg == '0);
    assign ok       = (d.status == ST_OK);
    assign res_last = hdr ? !ok : (cnt_reg == d.rank);
    assign load     = q_head.valid && (!valid_reg || m_axis_tready);
    assign q_pop    = load && res_last;

    always_comb begin
        dim_ext  = '0;
        dim_box  = '0;
        dim_strd = '0;
        case (cnt_reg)
            3'd1: begin
                dim_ext  = d.ext[0];
                dim_box  = d.box[0];
                dim_strd = (d.rank >= 3'd3) ? {33'd0, d.esize} : '0;
            end
            3'd2: begin
                dim_ext  = d.ext[1];
                dim_box  = d.box[1];
                dim_strd = {d.strd[0], 4'd0};
            end
            3'd3: begin
                dim_ext  = d.ext[2];
                dim_box  = d.box[2];
                dim_strd = {d.strd[1], 4'd0};
            end
            3'd4: begin
                dim_ext  = d.ext[3];
                dim_box  = d.box[3];
                dim_strd = {d.strd[2], 4'd0};
            end
            3'd5: begin
                dim_ext  = d.ext[4];
                dim_box  = d.box[4];
                dim_strd = {d.strd[3], 4'd0};
            end
            default: begin
                dim_ext  = '0;
                dim_box  = '0;
                dim_strd = '0;
            end
        endcase
    end

    always_comb begin
        res_next = '0;
        if (hdr) begin
            res_next.status = d.status;
            res_next.rank   = d.rank;
            if (ok) begin
                res_next.element_kind = d.kind;
                res_next.element_size = d.esize;
                // swizzle span is 16 << code, none for code zero
                res_next.swizzle_size = (d.swz == '0) ? 8'd0 : (8'd16 << d.swz);
                res_next.base_address = d.base;
            end
        end else begin
            res_next.dim_index   = cnt_reg - 3'd1;
            res_next.extent      = dim_ext + 32'd1;
            res_next.box_size    = {1'b0, dim_box} + 9'd1;
            res_next.stride_size = dim_strd;
        end
    end

    always_comb begin
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (load) begin
            cnt_next   = res_last ? 3'd0 : cnt_reg + 3'd1;
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg  <= res_next;
            user_reg <= !hdr;
            last_reg <= res_last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(M_DATA_W - RES_W){1'b0}}, res_reg};
    assign m_axis_tuser  = user_reg;
    assign m_axis_tlast  = last_reg;

`ifndef SYNTHESIS
    a_reject_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !user_reg && res_reg.status != ST_OK) |-> last_reg)
        else $error("rejected descriptor header not marked last");

    a_cnt_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_head.valid |-> (cnt_reg <= q_head.desc.rank))
        else $error("dimension counter beyond descriptor rank");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_head.valid)
        else $error("queue popped while empty");

    a_ok_header_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !user_reg && res_reg.status == ST_OK) |-> !last_reg)
        else $error("accepted descriptor header marked last");
`endif

endmodule

>>> hw/rtl/compact_tensor_descriptor_decode.sv
// top level of the compact tensor descriptor decoder
// Takes one 512-bit descriptor per request and returns a header result followed,
// for an accepted descriptor, by one result per dimension (1 to 6 results in all).
// The back end emits one result per cycle while a descriptor is queued and the
// receiver is ready, so a descriptor of rank r yields r+1 results and a rejected
// one a single result; that result sequencer sets the sustained rate. Classification
// happens in the cycle a descriptor is taken, and a two-entry queue lets the input
// accept the next descriptor while earlier results are still being delivered.
// Results come out of a register, loaded from the head of the queue whenever the
// output register is empty or its result is being taken.
module compact_tensor_descriptor_decode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // word0 [63:0], word1 [127:64], ... word7 [511:448]
    input  logic [ctdd_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status, rank, element_kind, element_size, swizzle_size, base_address,
    // dim_index, extent, box_size, stride_size, zero fill
    output logic [ctdd_pkg::M_DATA_W-1:0] m_axis_tdata,
    // is_dimension
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast
);
    import ctdd_pkg::*;

    logic    q_full;
    logic    q_push;
    desc_t   q_desc;
    q_head_t q_head;
    logic    q_pop;

    ctdd_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_desc        (q_desc)
    );

    ctdd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (q_desc),
        .full      (q_full),
        .head      (q_head),
        .pop       (q_pop)
    );

    ctdd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> tb/compact_tensor_descriptor_decode_test.sv
// self-checking testbench of the compact tensor descriptor decoder
module compact_tensor_descriptor_decode_test;
    import ctdd_pkg::*;

    typedef logic [7:0][63:0] descriptor_t;

    typedef struct {
        logic is_dimension;
        logic last;
        res_t fields;
    } decoded_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // word0 [63:0], word1 [127:64], ... word7 [511:448]
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // status, rank, element_kind, element_size, swizzle_size, base_address,
    // dim_index, extent, box_size, stride_size, zero fill
    logic [M_DATA_W-1:0]   m_axis_tdata;
    // is_dimension
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    decoded_result_t decoded_q[$];
    decoded_result_t wanted;
    res_t            seen;
    int              sender_idle_pct;
    int              receiver_stall_pct;
    bit              failed;

    compact_tensor_descriptor_decode DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [2:0] rank_of_format(logic [15:0] code);
        case (code)
            FMT_1D_U32, FMT_1D_F32: return 3'd1;
            FMT_2D_F16, FMT_2D_F32: return 3'd2;
            FMT_3D:                 return 3'd3;
            FMT_4D:                 return 3'd4;
            FMT_5D:                 return 3'd5;
            default:                return 3'd0;
        endcase
    endfunction

    // first failing check wins: control, reserved bits, strides, extents
    function automatic status_t classify(descriptor_t w, logic [2:0] rank,
                                         logic [4:0][31:0] strd, logic [4:0][31:0] ext);
        logic [15:0] ctl;
        int i;
        ctl = w[1][31:16];
        if (rank == 3'd1) begin
            if (w[1][63:16] != 0) return ST_CONTROL;
            if (w[2] != 0 || w[3] != 0 || w[5] != 0 || w[4][63:32] != 0 ||
                w[6][55:0] != 0 || w[7] != 0)
                return ST_RESERVED;
        end else if (rank == 3'd2) begin
            if (ctl != 0 && ctl != CTL_2D_ALT) return ST_CONTROL;
            if (w[2] != 0 || w[3] != 0 || w[5] != 0 || w[6][55:0] != 0 ||
                w[7][63:8] != 0)
                return ST_RESERVED;
        end else begin
            if (ctl != 0) return ST_CONTROL;
            if (rank == 3'd3) begin
                if (w[2][63:32] != 0 || w[3] != 0 || w[5][63:32] != 0 ||
                    w[6][55:0] != 0 || w[7][63:16] != 0)
                    return ST_RESERVED;
            end else if (rank == 3'd4) begin
                if (w[3] != 0 || w[6][55:0] != 0 || w[7][63:24] != 0)
                    return ST_RESERVED;
            end else begin
                if (w[3][63:32] != 0 || w[6][55:32] != 0 || w[7][63:32] != 0)
                    return ST_RESERVED;
            end
        end
        for (i = 1; i < rank; i++)
            if (strd[i] == 0) return ST_STRIDE;
        for (i = 0; i < rank; i++)
            if (ext[i] == 32'hffff_ffff) return ST_EXTENT;
        return ST_OK;
    endfunction

    // queues the header and, for an accepted request, the per-dimension results
    function automatic void decode_descriptor(descriptor_t w);
        logic [15:0]      code;
        logic [1:0]       swz;
        logic [2:0]       rank;
        logic [4:0][31:0] ext;
        logic [4:0][31:0] strd;
        logic [4:0][7:0]  box;
        status_t          st;
        elem_kind_t       kind;
        logic [2:0]       esize;
        decoded_result_t  head;
        decoded_result_t  dim;
        int               i;
        code = w[1][15:0] & ~FMT_SWZ_MASK;
        swz  = w[1][14:13];
        rank = rank_of_format(code);
        ext  = {w[6][31:0], w[5][63:32], w[5][31:0], w[4][63:32], w[4][31:0]};
        box  = {w[7][31:24], w[7][23:16], w[7][15:8], w[7][7:0], w[6][63:56]};
        strd = {w[3][31:0], w[2][63:32], w[2][31:0], w[1][63:32], 32'd0};
        st = (rank == 3'd0) ? ST_FORMAT : classify(w, rank, strd, ext);

        head.fields = '0;
        head.is_dimension = 1'b0;
        head.fields.status = st;
        head.fields.rank = rank;
        head.last = (st != ST_OK);
        if (st != ST_OK) begin
            decoded_q.push_back(head);
            return;
        end

        if (code == FMT_1D_U32) begin
            kind = KIND_U32;
            esize = 3'd4;
        end else if (code == FMT_2D_F16) begin
            kind = KIND_F16;
            esize = 3'd2;
        end else begin
            kind = KIND_F32;
            esize = 3'd4;
        end
        head.fields.element_kind = kind;
        head.fields.element_size = esize;
        head.fields.swizzle_size = (swz == 2'd0) ? 8'd0 : 8'(16 << swz);
        head.fields.base_address = w[0];
        decoded_q.push_back(head);

        for (i = 0; i < rank; i++) begin
            dim.fields = '0;
            dim.is_dimension = 1'b1;
            dim.fields.dim_index = 3'(i);
            dim.fields.extent = ext[i] + 32'd1;
            dim.fields.box_size = {1'b0, box[i]} + 9'd1;
            if (i == 0)
                dim.fields.stride_size = (rank >= 3'd3) ? 36'(esize) : 36'd0;
            else
                dim.fields.stride_size = {strd[i], 4'd0};
            dim.last = (i == rank - 1);
            decoded_q.push_back(dim);
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failed = 1'b1;
        end
    endfunction

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                $error("result with no request outstanding: tdata %h", m_axis_tdata);
                failed = 1'b1;
            end else begin
                wanted = decoded_q.pop_front();
                seen = m_axis_tdata[RES_W-1:0];
                check_field("is_dimension", wanted.is_dimension, m_axis_tuser);
                check_field("last", wanted.last, m_axis_tlast);
                check_field("status", wanted.fields.status, seen.status);
                check_field("rank", wanted.fields.rank, seen.rank);
                check_field("element_kind", wanted.fields.element_kind, seen.element_kind);
                check_field("element_size", wanted.fields.element_size, seen.element_size);
                check_field("swizzle_size", wanted.fields.swizzle_size, seen.swizzle_size);
                check_field("base_address", wanted.fields.base_address, seen.base_address);
                check_field("dim_index", wanted.fields.dim_index, seen.dim_index);
                check_field("extent", wanted.fields.extent, seen.extent);
                check_field("box_size", wanted.fields.box_size, seen.box_size);
                check_field("stride_size", wanted.fields.stride_size, seen.stride_size);
                check_field("tdata fill", 64'd0, m_axis_tdata[M_DATA_W-1:RES_W]);
            end
        end
    end

    function automatic logic [31:0] rand_extent();
        logic [31:0] v;
        case ($urandom_range(5))
            0: v = 32'd0;
            1: v = 32'hffff_fffe;
            2: v = 32'($urandom_range(15));
            default: begin
                v = $urandom;
                if (v == 32'hffff_ffff) v = 32'hffff_fffe;
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_stride();
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = 32'd1;
            1: v = 32'hffff_ffff;
            default: begin
                v = $urandom;
                if (v == 32'd0) v = 32'd1;
            end
        endcase
        return v;
    endfunction

    // descriptor of the format's rank with random content, well-formed for a valid control word
    function automatic descriptor_t build_descriptor(logic [15:0] code, logic [1:0] swz,
                                                     logic [15:0] ctl);
        descriptor_t      w;
        logic [2:0]       rank;
        logic [4:0][31:0] ext;
        logic [4:0][31:0] strd;
        logic [4:0][7:0]  box;
        int               i;
        rank = rank_of_format(code);
        for (i = 0; i < 5; i++) begin
            ext[i]  = (i < rank) ? rand_extent() : 32'd0;
            box[i]  = (i < rank) ? 8'($urandom) : 8'd0;
            strd[i] = (i > 0 && i < rank) ? rand_stride() : 32'd0;
        end
        w[0] = {$urandom, $urandom};
        w[1] = {strd[1], ctl, code | (16'(swz) << 13)};
        w[2] = {strd[3], strd[2]};
        w[3] = {32'd0, strd[4]};
        w[4] = {ext[1], ext[0]};
        w[5] = {ext[3], ext[2]};
        w[6] = {box[0], 24'd0, ext[4]};
        w[7] = {32'd0, box[4], box[3], box[2], box[1]};
        return w;
    endfunction

    function automatic logic [15:0] pick_format();
        case ($urandom_range(6))
            0: return FMT_1D_U32;
            1: return FMT_1D_F32;
            2: return FMT_2D_F16;
            3: return FMT_2D_F32;
            4: return FMT_3D;
            5: return FMT_4D;
            default: return FMT_5D;
        endcase
    endfunction

    // mostly well-formed, the rest broken in one spot or pure noise
    function automatic descriptor_t random_descriptor();
        descriptor_t w;
        logic [15:0] code;
        logic [2:0]  rank;
        logic [15:0] ctl;
        int          dim;
        int          bitpos;
        int          i;
        code = pick_format();
        rank = rank_of_format(code);
        ctl = (rank == 3'd2 && $urandom_range(1) == 1) ? CTL_2D_ALT : 16'h0000;
        w = build_descriptor(code, 2'($urandom_range(3)), ctl);
        if ($urandom_range(99) < 70) return w;
        case ($urandom_range(5))
            0: begin
                bitpos = $urandom_range(447);
                w[1 + bitpos / 64][bitpos % 64] = ~w[1 + bitpos / 64][bitpos % 64];
            end
            1: w[1][15:0] = 16'($urandom);
            2: if (rank >= 3'd2) begin
                dim = $urandom_range(rank - 1, 1);
                case (dim)
                    1: w[1][63:32] = 32'd0;
                    2: w[2][31:0] = 32'd0;
                    3: w[2][63:32] = 32'd0;
                    default: w[3][31:0] = 32'd0;
                endcase
            end
            3: begin
                dim = $urandom_range(rank - 1, 0);
                case (dim)
                    0: w[4][31:0] = '1;
                    1: w[4][63:32] = '1;
                    2: w[5][31:0] = '1;
                    3: w[5][63:32] = '1;
                    default: w[6][31:0] = '1;
                endcase
            end
            4: w[1][31:16] = 16'($urandom);
            default: for (i = 0; i < 8; i++) w[i] = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    task automatic send_descriptor(descriptor_t w);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        decode_descriptor(w);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (decoded_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_each_format();
        send_descriptor(build_descriptor(FMT_1D_U32, 2'd0, 16'h0000));
        send_descriptor(build_descriptor(FMT_1D_F32, 2'd1, 16'h0000));
        send_descriptor(build_descriptor(FMT_2D_F16, 2'd2, 16'h0000));
        send_descriptor(build_descriptor(FMT_2D_F32, 2'd3, 16'h0000));
        send_descriptor(build_descriptor(FMT_3D, 2'd0, 16'h0000));
        send_descriptor(build_descriptor(FMT_4D, 2'd1, 16'h0000));
        send_descriptor(build_descriptor(FMT_5D, 2'd2, 16'h0000));
        send_descriptor(build_descriptor(FMT_2D_F16, 2'd3, CTL_2D_ALT));
        wait_for_results();
    endtask

    task automatic test_rejections();
        descriptor_t w;
        send_descriptor('0);
        send_descriptor('1);
        // stride field of a 1d descriptor counts as control
        w = build_descriptor(FMT_1D_F32, 2'd0, 16'h0000);
        w[1][40] = 1'b1;
        send_descriptor(w);
        send_descriptor(build_descriptor(FMT_2D_F32, 2'd0, 16'h0021));
        send_descriptor(build_descriptor(FMT_3D, 2'd1, CTL_2D_ALT));
        w = build_descriptor(FMT_3D, 2'd1, 16'h0000);
        w[3][0] = 1'b1;
        send_descriptor(w);
        // reserved bit and zero stride together, reserved reported
        w = build_descriptor(FMT_2D_F16, 2'd0, 16'h0000);
        w[7][8] = 1'b1;
        w[1][63:32] = 32'd0;
        send_descriptor(w);
        w = build_descriptor(FMT_5D, 2'd0, 16'h0000);
        w[3][31:0] = 32'd0;
        send_descriptor(w);
        w = build_descriptor(FMT_4D, 2'd2, 16'h0000);
        w[5][63:32] = '1;
        send_descriptor(w);
        w = build_descriptor(FMT_1D_U32, 2'd0, 16'h0000);
        w[4][31:0] = '1;
        send_descriptor(w);
        w = build_descriptor(FMT_5D, 2'd0, 16'h0000);
        w[1][15] = 1'b1;
        send_descriptor(w);
        wait_for_results();
    endtask

    task automatic test_field_extremes();
        descriptor_t w;
        w = build_descriptor(FMT_5D, 2'd3, 16'h0000);
        w[0] = '1;
        w[1][63:32] = '1;
        w[2] = '1;
        w[3][31:0] = '1;
        w[4] = {2{32'hffff_fffe}};
        w[5] = {2{32'hffff_fffe}};
        w[6] = {8'hff, 24'd0, 32'hffff_fffe};
        w[7][31:0] = '1;
        send_descriptor(w);
        w = build_descriptor(FMT_5D, 2'd0, 16'h0000);
        w[0] = '0;
        w[1][63:32] = 32'd1;
        w[2] = {32'd1, 32'd1};
        w[3] = 64'd1;
        w[4] = '0;
        w[5] = '0;
        w[6] = '0;
        w[7] = '0;
        send_descriptor(w);
        w = build_descriptor(FMT_1D_F32, 2'd3, 16'h0000);
        w[0] = '1;
        w[4][31:0] = 32'hffff_fffe;
        w[6][63:56] = 8'hff;
        send_descriptor(w);
        wait_for_results();
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, int count);
        int n;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (n = 0; n < count; n++)
            send_descriptor(random_descriptor());
        wait_for_results();
    endtask

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        failed = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_each_format();
        test_rejections();
        test_field_extremes();
        test_random_traffic(0, 0, 32);
        test_random_traffic(81, 0, 32);
        test_random_traffic(0, 81, 32);
        test_random_traffic(18, 18, 32);
        // catch any result beyond the last expected one
        repeat (20) @(posedge aclk);
        if (!failed)
            $display("PASS compact_tensor_descriptor_decode");
        else
            $display("FAIL compact_tensor_descriptor_decode");
        $finish;
    end

    initial begin
        #800000;
        $display("FAIL compact_tensor_descriptor_decode");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ctdd_pkg.sv
hw/rtl/ctdd_front.sv
hw/rtl/ctdd_queue.sv
hw/rtl/ctdd_back.sv
hw/rtl/compact_tensor_descriptor_decode.sv
tb/compact_tensor_descriptor_decode_test.sv
